// ----- sv/bbdq_pkg.sv -----
package bbdq_pkg;

    localparam int ITEM_W  = 16;
    localparam int TIME_W  = 32;
    localparam int BYTES_W = 24;
    localparam int LEN_W   = 7;
    localparam int CFG_IW  = 1;
    localparam int CFG_DW  = 24;

    // request codes
    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    // register indexes
    localparam logic [CFG_IW-1:0] REG_MAX_DEPTH = 1'b0;
    localparam logic [CFG_IW-1:0] REG_MAX_BYTES = 1'b1;

    localparam logic [LEN_W-1:0]   MAX_DEPTH_RST = 7'd64;
    localparam logic [BYTES_W-1:0] MAX_BYTES_RST = 24'd1048576;

    typedef struct packed {
        logic              req_type;
        logic [ITEM_W-1:0] item_tag;
        logic [ITEM_W-1:0] item_size;
        logic [TIME_W-1:0] time_now;
    } t_req;

    typedef struct packed {
        logic               accepted;
        logic [LEN_W-1:0]   drop_count;
        logic [ITEM_W-1:0]  pop_tag;
        logic [ITEM_W-1:0]  pop_size;
        logic [TIME_W-1:0]  pop_time;
        logic [LEN_W-1:0]   queue_length;
        logic [BYTES_W-1:0] queue_bytes;
    } t_rsp;

    // one stored descriptor
    typedef struct packed {
        logic [ITEM_W-1:0] tag;
        logic [ITEM_W-1:0] size;
        logic [TIME_W-1:0] stamp;
    } t_entry;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_EVAL  = 5'b00010,
        S_DROP  = 5'b00100,
        S_WRITE = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

endpackage

// ----- sv/byte_budget_drop_oldest_queue_top.sv -----
// channel   dir  handshake             payload
// in        in   i_in_valid/o_in_stall  t_req  (req_type, item_tag, item_size, time_now)
// out       out  o_out_valid/i_out_stall t_rsp (accepted .. queue_bytes)
// cfg       in   i_cfg_valid/o_cfg_ready index 0 max_depth, index 1 max_bytes
//
// pop or push without drops: eval, then drop (pop) or write (push), then done loads the result
// rejected push or pop on empty: eval goes straight to done
// each dropped head entry adds a compare pass and a subtract pass on the shared adder
// reset is synchronous active low; pointers, count, byte total clear and limits reload
// o_in_stall is high from accept until the result is loaded into the output register;
// the output register holds while i_out_stall is high, the next item may already be in work
module byte_budget_drop_oldest_queue_top #(
    parameter int DEPTH = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  bbdq_pkg::t_req                  i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output bbdq_pkg::t_rsp                  o_out_data,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [bbdq_pkg::CFG_IW-1:0]     i_cfg_index,
    input  logic [bbdq_pkg::CFG_DW-1:0]     i_cfg_data
);

    import bbdq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = (CW > LEN_W) ? CW : LEN_W;

    // sequencer and queue bookkeeping
    t_state             r_state, n_state;
    logic [AW-1:0]      r_head, n_head;
    logic [AW-1:0]      r_tail, n_tail;
    logic [CW-1:0]      r_count, n_count;
    logic [BYTES_W-1:0] r_total, n_total;
    logic [LEN_W-1:0]   r_max_depth, n_max_depth;
    logic [BYTES_W-1:0] r_max_bytes, n_max_bytes;

    // per-request working registers
    t_req               r_req, n_req;
    logic               r_acc, n_acc;
    logic [LEN_W-1:0]   r_drops, n_drops;
    t_entry             r_pop, n_pop;

    // output register
    logic               r_out_valid, n_out_valid;
    t_rsp               r_out, n_out;

    t_entry             rd_entry;
    logic [$bits(t_entry)-1:0] rd_bits;
    logic               ram_we;

    logic               in_take;
    logic               out_free;

    // shared arithmetic unit: total + size, or total - head size
    logic               au_sub;
    logic [BYTES_W:0]   au_b;
    logic [BYTES_W:0]   au_sum;
    logic [BYTES_W-1:0] au_clamped;
    logic               au_over;

    logic [LW-1:0]      md_ext;
    logic [LW-1:0]      lim;
    logic [LW-1:0]      cnt_ext;
    logic               need_drop;

    bbdq_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_tail),
        .i_wdata ({r_req.item_tag, r_req.item_size, r_req.time_now}),
        .i_raddr (r_head),
        .o_rdata (rd_bits)
    );

    assign rd_entry = t_entry'(rd_bits);
    assign ram_we   = (r_state == S_WRITE);

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign in_take  = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    // subtract only while removing the head entry
    assign au_sub = (r_state == S_DROP);
    assign au_b   = au_sub ? ~{{(BYTES_W + 1 - ITEM_W){1'b0}}, rd_entry.size}
                           : {{(BYTES_W + 1 - ITEM_W){1'b0}}, r_req.item_size};
    assign au_sum = {1'b0, r_total} + au_b + {{BYTES_W{1'b0}}, au_sub};
    // borrow shows as the top bit; the byte total floors at zero
    assign au_clamped = au_sum[BYTES_W] ? '0 : au_sum[BYTES_W-1:0];
    assign au_over    = (au_sum > {1'b0, r_max_bytes});

    // depth limit clamped into 1..DEPTH
    assign md_ext  = LW'(r_max_depth);
    assign cnt_ext = LW'(r_count);
    always_comb begin
        if (md_ext == '0) begin
            lim = LW'(1);
        end else if (md_ext > LW'(DEPTH)) begin
            lim = LW'(DEPTH);
        end else begin
            lim = md_ext;
        end
    end

    assign need_drop = (r_count != '0) && ((cnt_ext >= lim) || au_over);

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_total     = r_total;
        n_max_depth = r_max_depth;
        n_max_bytes = r_max_bytes;
        n_req       = r_req;
        n_acc       = r_acc;
        n_drops     = r_drops;
        n_pop       = r_pop;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_MAX_DEPTH: n_max_depth = i_cfg_data[LEN_W-1:0];
                REG_MAX_BYTES: n_max_bytes = i_cfg_data[BYTES_W-1:0];
                default:       ;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    n_req   = i_in_data;
                    n_acc   = 1'b0;
                    n_drops = '0;
                    n_pop   = '0;
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (r_req.req_type == REQ_POP) begin
                    n_state = (r_count != '0) ? S_DROP : S_DONE;
                end else if ({8'd0, r_req.item_size} > r_max_bytes) begin
                    // oversize push is rejected untouched
                    n_state = S_DONE;
                end else if (need_drop) begin
                    n_state = S_DROP;
                end else begin
                    n_state = S_WRITE;
                end
            end
            S_DROP: begin
                // head read data settled during the previous cycle
                n_total = au_clamped;
                n_count = r_count - CW'(1);
                n_head  = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + AW'(1);
                if (r_req.req_type == REQ_POP) begin
                    n_pop   = rd_entry;
                    n_acc   = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_drops = r_drops + LEN_W'(1);
                    n_state = S_EVAL;
                end
            end
            S_WRITE: begin
                n_tail  = (r_tail == AW'(DEPTH - 1)) ? '0 : r_tail + AW'(1);
                n_count = r_count + CW'(1);
                n_total = au_sum[BYTES_W-1:0];
                n_acc   = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out.accepted     = r_acc;
                    n_out.drop_count   = r_drops;
                    n_out.pop_tag      = r_pop.tag;
                    n_out.pop_size     = r_pop.size;
                    n_out.pop_time     = r_pop.stamp;
                    n_out.queue_length = cnt_ext[LEN_W-1:0];
                    n_out.queue_bytes  = r_total;
                    n_out_valid        = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_total     <= '0;
            r_max_depth <= MAX_DEPTH_RST;
            r_max_bytes <= MAX_BYTES_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_total     <= n_total;
            r_max_depth <= n_max_depth;
            r_max_bytes <= n_max_bytes;
            r_out_valid <= n_out_valid;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_req   <= n_req;
        r_acc   <= n_acc;
        r_drops <= n_drops;
        r_pop   <= n_pop;
        r_out   <= n_out;
    end

endmodule

// ----- sv/bbdq_ram.sv -----
module bbdq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- test/tb.sv -----
module tb;
    import bbdq_pkg::*;

    localparam int QDEPTH   = 64;
    localparam int PTR_W    = $clog2(QDEPTH);
    // the slowest legal run stays well inside this limit, leaving a wide margin
    localparam int LIMIT    = 400000;
    localparam int MAX_SHOW = 10;
    localparam int PHASES   = 12;
    localparam int PER_PH   = 137;

    // clock, reset and every block input start at a known value
    logic              i_clk     = 1'b0;
    logic              i_rst_n   = 1'b0;
    logic              in_valid  = 1'b0;
    t_req              in_data   = '0;
    logic              out_stall = 1'b0;
    logic              cfg_valid = 1'b0;
    logic [CFG_IW-1:0] cfg_index = '0;
    logic [CFG_DW-1:0] cfg_data  = '0;

    logic in_stall;
    logic out_valid;
    logic cfg_ready;
    t_rsp out_data;

    byte_budget_drop_oldest_queue_top #(
        .DEPTH(QDEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // requests waiting to be driven, responses waiting to come out
    t_req req_pending [$];
    t_rsp rsp_expected [$];

    // shadow copy of the descriptor queue
    t_entry             shadow_slot [QDEPTH];
    logic [PTR_W-1:0]   shadow_head  = '0;
    logic [PTR_W-1:0]   shadow_tail  = '0;
    int unsigned        shadow_count = 0;
    logic [BYTES_W-1:0] shadow_bytes = '0;
    logic [LEN_W-1:0]   lim_depth    = MAX_DEPTH_RST;
    logic [BYTES_W-1:0] lim_bytes    = MAX_BYTES_RST;

    // run statistics
    int unsigned beats_in    = 0;
    int unsigned beats_out   = 0;
    int unsigned mismatches  = 0;
    int unsigned n_push      = 0;
    int unsigned n_pop       = 0;
    int unsigned n_reject    = 0;
    int unsigned n_empty     = 0;
    int unsigned n_dropped   = 0;
    int unsigned max_dropped = 0;
    int unsigned reg_writes  = 0;

    // retire the head entry, byte total saturates at zero
    function automatic void retire_head();
        if (shadow_bytes >= shadow_slot[shadow_head].size)
            shadow_bytes = shadow_bytes - shadow_slot[shadow_head].size;
        else
            shadow_bytes = '0;
        shadow_count--;
        shadow_head++;
    endfunction

    // advance the shadow queue by one request, return the response it must give
    function automatic t_rsp queue_admit(t_req r);
        t_rsp        rsp;
        int unsigned cap;
        int unsigned drops;
        rsp   = '0;
        drops = 0;
        if (r.req_type == REQ_PUSH) begin
            if (r.item_size <= lim_bytes) begin
                // depth limit of 0 behaves as 1, above the store size as the store size
                if (lim_depth == 0)
                    cap = 1;
                else if (lim_depth > QDEPTH)
                    cap = QDEPTH;
                else
                    cap = int'(lim_depth);
                while (shadow_count > 0 && (shadow_count >= cap ||
                       int'(shadow_bytes) + int'(r.item_size) > int'(lim_bytes))) begin
                    retire_head();
                    drops++;
                end
                shadow_slot[shadow_tail].tag   = r.item_tag;
                shadow_slot[shadow_tail].size  = r.item_size;
                shadow_slot[shadow_tail].stamp = r.time_now;
                shadow_tail++;
                shadow_count++;
                shadow_bytes = shadow_bytes + r.item_size;
                rsp.accepted = 1'b1;
            end
        end else if (shadow_count > 0) begin
            rsp.pop_tag  = shadow_slot[shadow_head].tag;
            rsp.pop_size = shadow_slot[shadow_head].size;
            rsp.pop_time = shadow_slot[shadow_head].stamp;
            retire_head();
            rsp.accepted = 1'b1;
        end
        rsp.drop_count   = LEN_W'(drops);
        rsp.queue_length = LEN_W'(shadow_count);
        rsp.queue_bytes  = shadow_bytes;
        return rsp;
    endfunction

    // request driver: one beat per accept, random gap drawn per item
    int in_gap  = 0;
    bit in_calm = 1'b0;

    always @(posedge i_clk) begin : drive_req
        logic v_next;
        t_rsp want;
        v_next = in_valid;
        if (i_rst_n) begin
            if (in_valid && !in_stall) begin
                want = queue_admit(in_data);
                rsp_expected.push_back(want);
                beats_in++;
                if (in_data.req_type == REQ_PUSH) begin
                    n_push++;
                    if (!want.accepted) n_reject++;
                    n_dropped += int'(want.drop_count);
                    if (want.drop_count > max_dropped) max_dropped = int'(want.drop_count);
                end else begin
                    n_pop++;
                    if (!want.accepted) n_empty++;
                end
                v_next = 1'b0;
            end
            if (!v_next) begin
                if (in_gap > 0) begin
                    in_gap--;
                end else if (req_pending.size() > 0) begin
                    in_data <= req_pending.pop_front();
                    v_next = 1'b1;
                    // runs of back-to-back items alternate with gappy runs
                    if ($urandom_range(0, 7) == 0) in_calm = !in_calm;
                    in_gap = in_calm ? 0 : $urandom_range(0, 16);
                end
            end
        end
        in_valid <= v_next;
    end

    // response monitor: checks each beat against the oldest prediction
    int out_hold = 0;
    bit out_calm = 1'b0;

    always @(posedge i_clk) begin : watch_rsp
        t_rsp  want;
        string bad;
        logic  s_next;
        s_next = out_stall;
        if (i_rst_n) begin
            if (out_valid && !out_stall) begin
                beats_out++;
                if (rsp_expected.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOW)
                        $display("unexpected response beat %0d: acc=%0d len=%0d bytes=%h",
                                 beats_out, out_data.accepted, out_data.queue_length,
                                 out_data.queue_bytes);
                end else begin
                    want = rsp_expected.pop_front();
                    bad  = "";
                    if (out_data.accepted !== want.accepted)         bad = {bad, " accepted"};
                    if (out_data.drop_count !== want.drop_count)     bad = {bad, " drop_count"};
                    if (out_data.pop_tag !== want.pop_tag)           bad = {bad, " pop_tag"};
                    if (out_data.pop_size !== want.pop_size)         bad = {bad, " pop_size"};
                    if (out_data.pop_time !== want.pop_time)         bad = {bad, " pop_time"};
                    if (out_data.queue_length !== want.queue_length) bad = {bad, " queue_length"};
                    if (out_data.queue_bytes !== want.queue_bytes)   bad = {bad, " queue_bytes"};
                    if (bad != "") begin
                        mismatches++;
                        if (mismatches <= MAX_SHOW) begin
                            $display("mismatch on response %0d:%s", beats_out, bad);
                            $display("  want acc=%0d drop=%0d tag=%h size=%h time=%h len=%0d bytes=%h",
                                     want.accepted, want.drop_count, want.pop_tag, want.pop_size,
                                     want.pop_time, want.queue_length, want.queue_bytes);
                            $display("  got  acc=%0d drop=%0d tag=%h size=%h time=%h len=%0d bytes=%h",
                                     out_data.accepted, out_data.drop_count, out_data.pop_tag,
                                     out_data.pop_size, out_data.pop_time, out_data.queue_length,
                                     out_data.queue_bytes);
                        end
                    end
                end
                // stall for the next beat drawn here
                if ($urandom_range(0, 7) == 0) out_calm = !out_calm;
                out_hold = out_calm ? 0 : $urandom_range(0, 16);
            end else if (out_valid && out_hold > 0) begin
                out_hold--;
            end
            s_next = (out_hold > 0);
        end
        out_stall <= s_next;
    end

    // monotonic stamp source, starts anywhere and wraps
    logic [TIME_W-1:0] stamp_now = '0;

    task automatic push_req(logic [ITEM_W-1:0] tag, logic [ITEM_W-1:0] size,
                            logic [TIME_W-1:0] stamp);
        t_req r;
        r.req_type  = REQ_PUSH;
        r.item_tag  = tag;
        r.item_size = size;
        r.time_now  = stamp;
        req_pending.push_back(r);
    endtask

    // pop with junk in the unused fields
    task automatic pop_req();
        t_req r;
        r.req_type  = REQ_POP;
        r.item_tag  = ITEM_W'($urandom);
        r.item_size = ITEM_W'($urandom);
        r.time_now  = $urandom;
        req_pending.push_back(r);
    endtask

    // wait until the block is idle with nothing outstanding
    // sampled on the falling edge so the driver's updates have landed
    task automatic settle();
        while (req_pending.size() != 0 || in_valid || rsp_expected.size() != 0)
            @(negedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
        if (idx == REG_MAX_DEPTH)
            lim_depth = val[LEN_W-1:0];
        else
            lim_bytes = val;
        reg_writes++;
    endtask

    // watchdog
    initial begin
        repeat (LIMIT) @(posedge i_clk);
        $display("timeout after %0d cycles, %0d responses outstanding",
                 LIMIT, rsp_expected.size());
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin : stimulus
        int unsigned       push_pct;
        int unsigned       scale;
        logic [LEN_W-1:0]  d;
        logic [CFG_DW-1:0] b;
        logic [ITEM_W-1:0] sz;

        stamp_now = $urandom;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset limits: empty pop, field extremes, drain to empty
        pop_req();
        push_req(16'h0000, 16'h0000, 32'h0000_0000);
        push_req(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        pop_req();
        pop_req();
        pop_req();
        settle();

        // small byte budget: reject oversize, exact fit, drops for bytes
        write_reg(REG_MAX_BYTES, 24'd100);
        push_req(16'h0011, 16'd101, 32'h0000_0010);
        push_req(16'h0012, 16'd100, 32'h0000_0020);
        push_req(16'h0013, 16'd60,  32'h0000_0030);
        push_req(16'h0014, 16'd40,  32'h0000_0040);
        push_req(16'h0015, 16'd1,   32'h0000_0050);
        pop_req();
        settle();

        // depth limit of zero behaves as one
        write_reg(REG_MAX_DEPTH, 24'd0);
        push_req(16'h0021, 16'd5, 32'h0000_0100);
        push_req(16'h0022, 16'd6, 32'h0000_0200);
        pop_req();
        pop_req();
        settle();

        // depth above the store size with upper data bits set, zero byte budget
        write_reg(REG_MAX_DEPTH, 24'hFFFFFF);
        write_reg(REG_MAX_BYTES, 24'd0);
        push_req(16'h0031, 16'd0, 32'h0000_1000);
        push_req(16'h0032, 16'd1, 32'h0000_2000);
        push_req(16'h0033, 16'd0, 32'h0000_3000);
        pop_req();
        settle();

        // depth one, full byte budget
        write_reg(REG_MAX_DEPTH, 24'd1);
        write_reg(REG_MAX_BYTES, 24'hFFFFFF);
        push_req(16'h0041, 16'hFFFF, 32'h8000_0000);
        push_req(16'h0042, 16'hFFFF, 32'h8000_0001);
        pop_req();
        settle();

        // fill to the full depth, overflow by one, then lower the byte budget
        // so the next push throws away every held entry
        write_reg(REG_MAX_DEPTH, 24'd64);
        repeat (QDEPTH + 1) begin
            stamp_now += $urandom_range(1, 500);
            push_req(ITEM_W'($urandom), ITEM_W'($urandom_range(1, 1000)), stamp_now);
        end
        settle();
        write_reg(REG_MAX_BYTES, 24'h00FFFF);
        push_req(16'hABCD, 16'hFFFF, stamp_now + 1);
        settle();

        // refill, then lower the depth limit under a full queue
        write_reg(REG_MAX_BYTES, 24'hFFFFFF);
        repeat (QDEPTH) begin
            stamp_now += $urandom_range(1, 500);
            push_req(ITEM_W'($urandom), ITEM_W'($urandom), stamp_now);
        end
        settle();
        write_reg(REG_MAX_DEPTH, 24'd3);
        push_req(16'h5A5A, 16'h0001, stamp_now + 2);
        pop_req();
        settle();

        // random phases, each with its own limits and push/pop mix
        for (int ph = 0; ph < PHASES; ph++) begin
            case ($urandom_range(0, 5))
                0:       d = 7'd0;
                1:       d = 7'd1;
                2:       d = LEN_W'($urandom_range(2, 8));
                3:       d = LEN_W'($urandom_range(1, 64));
                4:       d = 7'd64;
                default: d = LEN_W'($urandom_range(65, 127));
            endcase
            b = {CFG_DW{1'b0}};
            if ($urandom_range(0, 1) == 1) b = CFG_DW'($urandom);
            write_reg(REG_MAX_DEPTH, {b[CFG_DW-1:LEN_W], d});
            case ($urandom_range(0, 6))
                0:       b = 24'd0;
                1:       b = CFG_DW'($urandom_range(1, 255));
                2:       b = CFG_DW'($urandom_range(256, 65535));
                3:       b = 24'd65535;
                4:       b = CFG_DW'($urandom);
                5:       b = 24'hFFFFFF;
                default: b = MAX_BYTES_RST;
            endcase
            write_reg(REG_MAX_BYTES, b);

            case ($urandom_range(0, 3))
                0:       push_pct = 50;
                1:       push_pct = 70;
                2:       push_pct = 90;
                default: push_pct = 30;
            endcase
            // sizes scaled so the byte budget matters for most settings
            scale = int'(lim_bytes / 4);
            if (scale > 65535) scale = 65535;
            if (scale == 0) scale = 1;

            repeat (PER_PH) begin
                if ($urandom_range(0, 99) < push_pct) begin
                    case ($urandom_range(0, 9))
                        0:       sz = 16'h0000;
                        1:       sz = 16'hFFFF;
                        2, 3:    sz = ITEM_W'($urandom);
                        default: sz = ITEM_W'($urandom_range(0, scale));
                    endcase
                    stamp_now += $urandom_range(0, 5000);
                    push_req(ITEM_W'($urandom), sz, stamp_now);
                end else begin
                    pop_req();
                end
            end
            settle();
        end

        settle();
        repeat (20) @(posedge i_clk);
        // anything still waiting never came out
        if (rsp_expected.size() != 0) begin
            $display("%0d predicted responses never arrived", rsp_expected.size());
            mismatches += rsp_expected.size();
        end

        $display("%0d requests (%0d push, %0d pop), %0d responses checked, %0d register writes",
                 beats_in, n_push, n_pop, beats_out, reg_writes);
        $display("%0d pushes rejected, %0d pops on empty, %0d entries dropped (most %0d at once)",
                 n_reject, n_empty, n_dropped, max_dropped);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/bbdq_pkg.sv
sv/bbdq_ram.sv
sv/byte_budget_drop_oldest_queue_top.sv
test/tb.sv
